FILE: hdl/amru_pkg.sv
// ----------------------------------------------------------------------------
// amru_pkg: shared types and constants for the atomic read-modify-write unit
// Request/result structs, operation and type codes, controller states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package amru_pkg;

  localparam int unsigned MemWords = 1024;
  localparam int unsigned AddrW    = (MemWords > 1) ? $clog2(MemWords) : 1;
  localparam int unsigned InAddrW  = 10;

  typedef enum logic [2:0] {
    CMD_CAS  = 3'd0,
    CMD_ADD  = 3'd1,
    CMD_INC  = 3'd2,
    CMD_MAX  = 3'd3,
    CMD_MIN  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    TY_B32 = 2'd0,
    TY_U32 = 2'd1,
    TY_S32 = 2'd2,
    TY_F32 = 2'd3
  } dtype_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_FADD,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [1:0]  data_type;
    logic [9:0]  word_address;
    logic [31:0] operand_b;
    logic [31:0] operand_c;
    logic        last_in_packet;
  } in_req_t;

  typedef struct packed {
    logic [31:0] old_value;
    logic        bad_request;
    logic        packet_done;
  } out_res_t;

  localparam logic [31:0] QNan = 32'h7FC0_0000;

endpackage

FILE: hdl/amru_fadd.sv
// ----------------------------------------------------------------------------
// amru_fadd: two-stage binary32 adder, round to nearest even
// Stage 1 aligns and adds, stage 2 normalises and rounds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module amru_fadd (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] sum
);

  logic        sp_r, sp_nxt;
  logic [31:0] spv_r, spv_nxt;
  logic        sgn_r, sgn_nxt;
  logic [8:0]  e_r, e_nxt;
  logic [27:0] m_r, m_nxt;
  logic        sub_r, sub_nxt;

  // stage 1: specials, swap, align, add
  always_comb begin
    logic [31:0] x, y;
    logic [7:0]  ex, ey, d;
    logic [26:0] mx, my, sh;
    logic        stk;
    logic        nan_a, nan_b, inf_a, inf_b;
    stk   = 1'b0;
    nan_a = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    nan_b = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    inf_a = (a[30:0] == 31'h7F80_0000);
    inf_b = (b[30:0] == 31'h7F80_0000);
    sp_nxt  = 1'b1;
    spv_nxt = '0;
    if (nan_a || nan_b) spv_nxt = amru_pkg::QNan;
    else if (inf_a && inf_b) spv_nxt = (a[31] == b[31]) ? a : amru_pkg::QNan;
    else if (inf_a) spv_nxt = a;
    else if (inf_b) spv_nxt = b;
    else if (a[30:0] == '0 && b[30:0] == '0) spv_nxt = {a[31] & b[31], 31'd0};
    else if (a[30:0] == '0) spv_nxt = b;
    else if (b[30:0] == '0) spv_nxt = a;
    else sp_nxt = 1'b0;
    if (b[30:0] > a[30:0]) begin
      x = b; y = a;
    end else begin
      x = a; y = b;
    end
    ex = (x[30:23] != '0) ? x[30:23] : 8'd1;
    ey = (y[30:23] != '0) ? y[30:23] : 8'd1;
    mx = {(x[30:23] != '0), x[22:0], 3'b000};
    my = {(y[30:23] != '0), y[22:0], 3'b000};
    d  = ex - ey;
    if (d >= 8'd27) begin
      sh = {26'd0, (my != '0)};
    end else begin
      sh  = my >> d;
      stk = ((my & ((27'd1 << d) - 27'd1)) != '0);
      sh  = sh | {26'd0, stk};
    end
    sgn_nxt = x[31];
    sub_nxt = (x[31] != y[31]);
    e_nxt   = {1'b0, ex};
    m_nxt   = sub_nxt ? ({1'b0, mx} - {1'b0, sh}) : ({1'b0, mx} + {1'b0, sh});
  end

  always_ff @(posedge clk) begin
    sp_r  <= sp_nxt;
    spv_r <= spv_nxt;
    sgn_r <= sgn_nxt;
    e_r   <= e_nxt;
    m_r   <= m_nxt;
    sub_r <= sub_nxt;
  end

  // stage 2: normalise via leading-zero count, round
  always_comb begin
    logic [8:0]  e;
    logic [27:0] m;
    logic [4:0]  lz, sft;
    logic [2:0]  low;
    logic [24:0] r;
    logic        up;
    e   = e_r;
    m   = m_r;
    lz  = 5'd0;
    sft = 5'd0;
    for (int i = 26; i >= 0; i--) begin
      if (m[i] && lz == 5'd0 && m[26:0] >> (i + 1) == '0) lz = 5'(26 - i);
    end
    if (m[27]) begin
      m = {1'b0, m[27:2], m[1] | m[0]};
      e = e + 9'd1;
    end else if (sub_r) begin
      // shift limited so exponent does not fall below one
      sft = (e - 9'd1 < {4'd0, lz}) ? 5'(e - 9'd1) : lz;
      m   = m << sft;
      e   = e - {4'd0, sft};
    end
    low = m[2:0];
    r   = {1'b0, m[26:3]};
    up  = (low > 3'd4) || (low == 3'd4 && r[0]);
    r   = r + {24'd0, up};
    if (r[24]) begin
      r = r >> 1;
      e = e + 9'd1;
    end
    if (sp_r) sum = spv_r;
    else if (sub_r && m_r == '0) sum = '0;
    else if (e >= 9'd255) sum = {sgn_r, 31'h7F80_0000};
    else sum = {sgn_r, (r[23] ? e[7:0] : 8'd0), r[22:0]};
  end

endmodule

FILE: hdl/atomic_memory_rmw_unit_top.sv
// ----------------------------------------------------------------------------
// atomic_memory_rmw_unit_top: memory-side 32-bit atomic unit
// Word store with read, modify and write-back of one request at a time.
// ----------------------------------------------------------------------------
// Usage:
//  - A request (in_req) is taken at a clock edge with start high and busy low.
//  - The store is read (synchronous read into rd_r), the new word computed
//    and written back; old_value, bad_request and packet_done appear on out_res
//    with out_valid high for exactly one cycle.
//  - Integer ops: the word read from the store is modified and written back in
//    ST_READ; busy drops the cycle the result shows, so a new request is taken
//    only once the last result is out. f32 add goes through the two-stage
//    adder and writes back its sum in ST_FADD before busy drops.
//  - After reset a clearing pass writes zero to every word (MemWords, 1024),
//    with busy high throughout.
//  - The receiver cannot stall: each result is valid for one cycle only.
//  - Addresses wrap modulo MemWords.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module atomic_memory_rmw_unit_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  amru_pkg::in_req_t  in_req,
  output logic               out_valid,
  output amru_pkg::out_res_t out_res
);

  localparam int unsigned AW = amru_pkg::AddrW;

  logic [31:0] mem [amru_pkg::MemWords];
  logic [31:0] rd_r;

  amru_pkg::state_e state_r, state_nxt;
  amru_pkg::in_req_t req_r;
  logic [AW:0]       clr_r, clr_nxt;
  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [31:0]       wdata, nw, fsum;
  logic              bad;
  logic              valid_r, valid_nxt;
  amru_pkg::out_res_t res_r, res_nxt;

  assign raddr = AW'(in_req.word_address % amru_pkg::MemWords);

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_r <= mem[raddr];
  end

  amru_fadd u_fadd (.clk(clk), .a(req_r.operand_b), .b(rd_r), .sum(fsum));

  // op decode and integer result
  always_comb begin
    logic [31:0] ko, kb;
    ko  = (req_r.data_type == amru_pkg::TY_S32) ? (rd_r ^ 32'h8000_0000) : rd_r;
    kb  = (req_r.data_type == amru_pkg::TY_S32) ? (req_r.operand_b ^ 32'h8000_0000)
                                                 : req_r.operand_b;
    nw  = rd_r;
    bad = 1'b0;
    unique case (req_r.cmd)
      amru_pkg::CMD_CAS: begin
        if (req_r.data_type == amru_pkg::TY_B32 || req_r.data_type == amru_pkg::TY_U32)
          nw = (rd_r == req_r.operand_b) ? req_r.operand_c : rd_r;
        else bad = 1'b1;
      end
      amru_pkg::CMD_ADD: begin
        if (req_r.data_type == amru_pkg::TY_S32 || req_r.data_type == amru_pkg::TY_U32)
          nw = rd_r + req_r.operand_b;
        else if (req_r.data_type != amru_pkg::TY_F32) bad = 1'b1;
      end
      amru_pkg::CMD_INC: begin
        if (req_r.data_type == amru_pkg::TY_U32)
          nw = (rd_r >= req_r.operand_b) ? 32'd0 : rd_r + 32'd1;
        else bad = 1'b1;
      end
      amru_pkg::CMD_MAX: begin
        if (req_r.data_type == amru_pkg::TY_S32 || req_r.data_type == amru_pkg::TY_U32)
          nw = (ko > kb) ? rd_r : req_r.operand_b;
        else bad = 1'b1;
      end
      amru_pkg::CMD_MIN: begin
        if (req_r.data_type == amru_pkg::TY_S32 || req_r.data_type == amru_pkg::TY_U32)
          nw = (ko < kb) ? rd_r : req_r.operand_b;
        else bad = 1'b1;
      end
      default: bad = 1'b1;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    unique case (state_r)
      amru_pkg::ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (AW+1)'(amru_pkg::MemWords - 1)) state_nxt = amru_pkg::ST_IDLE;
      end
      amru_pkg::ST_IDLE:  if (start) state_nxt = amru_pkg::ST_READ;
      amru_pkg::ST_READ: begin
        if (req_r.cmd == amru_pkg::CMD_ADD && req_r.data_type == amru_pkg::TY_F32)
          state_nxt = amru_pkg::ST_FADD;
        else state_nxt = amru_pkg::ST_IDLE;
      end
      amru_pkg::ST_FADD:  state_nxt = amru_pkg::ST_IDLE;
      default:            state_nxt = amru_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    we        = 1'b0;
    waddr     = AW'(req_r.word_address % amru_pkg::MemWords);
    wdata     = nw;
    valid_nxt = 1'b0;
    res_nxt   = res_r;
    busy      = 1'b1;
    unique case (state_r)
      amru_pkg::ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_r[AW-1:0];
        wdata = '0;
      end
      amru_pkg::ST_IDLE: busy = 1'b0;
      amru_pkg::ST_READ: begin
        res_nxt = '{old_value: rd_r, bad_request: bad,
                    packet_done: req_r.last_in_packet};
        if (!(req_r.cmd == amru_pkg::CMD_ADD && req_r.data_type == amru_pkg::TY_F32)) begin
          we        = !bad;
          valid_nxt = 1'b1;
        end
      end
      amru_pkg::ST_FADD: begin
        we        = 1'b1;
        wdata     = fsum;
        valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= amru_pkg::ST_CLEAR;
      clr_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      valid_r <= valid_nxt;
    end
    res_r <= res_nxt;
    if (start && !busy) req_r <= in_req;
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

`ifndef ASSERT_OFF
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |=> !valid_r) else $error("back-to-back results");
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == amru_pkg::ST_IDLE |-> !we) else $error("write while idle");
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == amru_pkg::ST_FADD) |=> valid_r) else $error("f32 result lost");
  a_bad_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == amru_pkg::ST_READ && bad) |-> !we) else $error("bad request wrote");
`endif

endmodule
